// ----- hw/rtl/ptd_pkg.sv -----
`default_nettype none
package ptd_pkg;

    localparam int MAX_TASKS  = 4;
    localparam int NUM_REGS   = 4;
    localparam int NUM_TASKS  = (MAX_TASKS < NUM_REGS) ? MAX_TASKS : NUM_REGS;
    localparam int IDX_W      = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W      = $clog2(NUM_TASKS + 1);

    localparam int NOW_W      = 31;
    localparam int DL_W       = 32;
    localparam int PER_W      = 16;
    localparam int RUN_W      = 2;
    localparam int COUNT_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic               POLICY_RST = 1'b1;
    localparam logic [COUNT_W-1:0] COUNT_RST  = 3'd4;
    localparam logic [PER_W-1:0]   PERIOD_RST = 16'd100;
    localparam logic [NOW_W-1:0]   SLEEP_MAX  = {NOW_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLICY  = 3'd0,
        REG_COUNT   = 3'd1,
        REG_PERIOD0 = 3'd2,
        REG_PERIOD1 = 3'd3,
        REG_PERIOD2 = 3'd4,
        REG_PERIOD3 = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_SEL,
        ST_WAKE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                           policy;
        logic [COUNT_W-1:0]             count;
        logic [NUM_REGS-1:0][PER_W-1:0] period;
    } t_cfg;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [DL_W-1:0]  wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

endpackage
`default_nettype wire

// ----- hw/rtl/ptd_ifs.sv -----
`default_nettype none
interface ptd_in_if import ptd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [NOW_W-1:0] now_ms;
    logic             task_finished;

    modport source (output valid, output now_ms, output task_finished, input ready);
    modport sink (input valid, input now_ms, input task_finished, output ready);
endinterface

interface ptd_out_if import ptd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             run_valid;
    logic [RUN_W-1:0] run_task;
    logic             wake_valid;
    logic [NOW_W-1:0] sleep_ms;

    modport source (output valid, output run_valid, output run_task, output wake_valid,
                    output sleep_ms, input ready);
    modport sink (input valid, input run_valid, input run_task, input wake_valid,
                  input sleep_ms, output ready);
endinterface

interface ptd_cfg_if import ptd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/periodic_task_dispatcher.sv -----
`default_nettype none
// Input is accepted only in the idle state, so each item runs to its result beat before
// the next is taken: three sweeps over the deadline memory, whose single read port
// returns one entry per cycle.
// Reset: synchronous active-low; registers to policy EDF, four tasks, periods 100 ms;
// clears started, running task and done flags; deadlines stay unwritten until first beat.
module periodic_task_dispatcher import ptd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ptd_in_if.sink    i_in,
    ptd_out_if.source o_out,
    ptd_cfg_if.sink   i_cfg
);

    t_cfg            cfg;
    t_mem_req        mem_req;
    logic [DL_W-1:0] mem_rdata;

    ptd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    ptd_dl_mem u_dl_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    ptd_sweep u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (cfg),
        .o_mem   (mem_req),
        .i_rdata (mem_rdata)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/ptd_cfg_regs.sv -----
`default_nettype none
module ptd_cfg_regs import ptd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ptd_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.policy <= POLICY_RST;
            r_cfg.count  <= COUNT_RST;
            r_cfg.period <= {NUM_REGS{PERIOD_RST}};
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_POLICY:  r_cfg.policy    <= i_cfg.data[0];
                REG_COUNT:   r_cfg.count     <= i_cfg.data[COUNT_W-1:0];
                REG_PERIOD0: r_cfg.period[0] <= i_cfg.data[PER_W-1:0];
                REG_PERIOD1: r_cfg.period[1] <= i_cfg.data[PER_W-1:0];
                REG_PERIOD2: r_cfg.period[2] <= i_cfg.data[PER_W-1:0];
                REG_PERIOD3: r_cfg.period[3] <= i_cfg.data[PER_W-1:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/ptd_dl_mem.sv -----
`default_nettype none
module ptd_dl_mem import ptd_pkg::*; (
    input  wire logic            i_clk,
    input  wire t_mem_req        i_req,
    output logic [DL_W-1:0]      o_rdata
);

    logic [DL_W-1:0] r_mem [NUM_TASKS];
    logic [DL_W-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/ptd_sweep.sv -----
`default_nettype none
module ptd_sweep import ptd_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    ptd_in_if.sink               i_in,
    ptd_out_if.source            o_out,
    input  wire t_cfg            i_cfg,
    output t_mem_req             o_mem,
    input  wire logic [DL_W-1:0] i_rdata
);

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [CNT_W-1:0]       r_n, n_n;
    logic [NOW_W-1:0]       r_now, n_now;
    logic                   r_init, n_init;
    logic                   r_started, n_started;
    logic [IDX_W-1:0]       r_run_task, n_run_task;
    logic [NUM_TASKS-1:0]   r_done, n_done;
    logic                   r_sel_ok, n_sel_ok;
    logic [IDX_W-1:0]       r_sel, n_sel;
    logic [DL_W-1:0]        r_sel_dl, n_sel_dl;
    logic [PER_W-1:0]       r_sel_per, n_sel_per;
    logic                   r_wake_ok, n_wake_ok;
    logic [DL_W-1:0]        r_wake, n_wake;
    logic                   r_out_valid, n_out_valid;
    logic                   r_run_valid, n_run_valid;
    logic [RUN_W-1:0]       r_run_out, n_run_out;
    logic                   r_wake_valid, n_wake_valid;
    logic [NOW_W-1:0]       r_sleep, n_sleep;

    logic [CNT_W-1:0]       cfg_n;
    logic [IDX_W-1:0]       idx;
    logic                   proc;
    logic                   last;
    logic [PER_W-1:0]       per;
    logic [DL_W-1:0]        now_x;
    logic [DL_W-1:0]        dl0;
    logic                   due;
    logic [DL_W-1:0]        dl1;
    logic                   take;
    logic                   cand;
    logic [DL_W-1:0]        diff;

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.run_valid  = r_run_valid;
    assign o_out.run_task   = r_run_out;
    assign o_out.wake_valid = r_wake_valid;
    assign o_out.sleep_ms   = r_sleep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_started   <= 1'b0;
            r_run_task  <= '0;
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_started   <= n_started;
            r_run_task  <= n_run_task;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n          <= n_n;
        r_now        <= n_now;
        r_init       <= n_init;
        r_sel_ok     <= n_sel_ok;
        r_sel        <= n_sel;
        r_sel_dl     <= n_sel_dl;
        r_sel_per    <= n_sel_per;
        r_wake_ok    <= n_wake_ok;
        r_wake       <= n_wake;
        r_run_valid  <= n_run_valid;
        r_run_out    <= n_run_out;
        r_wake_valid <= n_wake_valid;
        r_sleep      <= n_sleep;
    end

    always_comb begin
        cfg_n = (i_cfg.count > COUNT_W'(NUM_TASKS)) ? CNT_W'(NUM_TASKS) : CNT_W'(i_cfg.count);
        idx   = IDX_W'(r_cnt - CNT_W'(1));
        proc  = (r_cnt != '0);
        last  = (r_cnt == r_n);
        per   = i_cfg.period[idx];
        now_x = {1'b0, r_now};
        dl0   = r_init ? (now_x + DL_W'(per)) : i_rdata;
        due   = (dl0 <= now_x);
        dl1   = due ? (dl0 + DL_W'(per)) : dl0;
        take  = !r_sel_ok || (i_cfg.policy ? (i_rdata <= r_sel_dl) : (per <= r_sel_per));
        cand  = !r_sel_ok || (i_cfg.policy
                    ? (({1'b0, i_rdata} + (DL_W + 1)'(per)) < {1'b0, r_sel_dl})
                    : (per < r_sel_per));
        diff  = r_wake - now_x;

        n_state      = r_state;
        n_cnt        = r_cnt;
        n_n          = r_n;
        n_now        = r_now;
        n_init       = r_init;
        n_started    = r_started;
        n_run_task   = r_run_task;
        n_done       = r_done;
        n_sel_ok     = r_sel_ok;
        n_sel        = r_sel;
        n_sel_dl     = r_sel_dl;
        n_sel_per    = r_sel_per;
        n_wake_ok    = r_wake_ok;
        n_wake       = r_wake;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_run_valid  = r_run_valid;
        n_run_out    = r_run_out;
        n_wake_valid = r_wake_valid;
        n_sleep      = r_sleep;

        o_mem.we    = 1'b0;
        o_mem.waddr = idx;
        o_mem.wdata = dl1;
        o_mem.raddr = (r_cnt < r_n) ? r_cnt[IDX_W-1:0] : '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_now     = i_in.now_ms;
                    n_init    = !r_started;
                    n_started = 1'b1;
                    n_n       = cfg_n;
                    n_cnt     = '0;
                    n_sel_ok  = 1'b0;
                    n_sel     = '0;
                    n_wake_ok = 1'b0;
                    if (r_started && i_in.task_finished) begin
                        n_done[r_run_task] = 1'b1;
                    end
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (proc) begin
                    o_mem.we = 1'b1;
                    if (r_init || due) begin
                        n_done[idx] = 1'b0;
                    end
                end
                n_cnt = last ? '0 : r_cnt + CNT_W'(1);
                if (last) begin
                    n_state = ST_SEL;
                end
            end
            ST_SEL: begin
                if (proc && !r_done[idx] && take) begin
                    n_sel_ok  = 1'b1;
                    n_sel     = idx;
                    n_sel_dl  = i_rdata;
                    n_sel_per = per;
                end
                n_cnt = last ? '0 : r_cnt + CNT_W'(1);
                if (last) begin
                    n_state = ST_WAKE;
                end
            end
            ST_WAKE: begin
                if (proc && cand && (!r_wake_ok || i_rdata < r_wake)) begin
                    n_wake_ok = 1'b1;
                    n_wake    = i_rdata;
                end
                n_cnt = last ? '0 : r_cnt + CNT_W'(1);
                if (last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_run_valid  = r_sel_ok;
                    n_run_out    = r_sel_ok ? RUN_W'(r_sel) : '0;
                    n_wake_valid = r_wake_ok;
                    if (r_wake_ok && r_wake > now_x) begin
                        n_sleep = diff[DL_W-1] ? SLEEP_MAX : diff[NOW_W-1:0];
                    end else begin
                        n_sleep = '0;
                    end
                    if (r_sel_ok) begin
                        n_run_task = r_sel;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_write_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.we |-> (r_state == ST_UPD))
        else $error("deadline write outside update sweep");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD || r_state == ST_SEL || r_state == ST_WAKE) |-> (r_cnt <= r_n))
        else $error("sweep counter past task count");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == ST_UPD && r_cnt == '0))
        else $error("accepted beat did not start update sweep");

    a_sel_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAKE && r_sel_ok) |-> !r_done[r_sel])
        else $error("selected task is marked done");

    a_started_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEL) |-> r_started)
        else $error("selection before first initialization");

endmodule
`default_nettype wire

// ----- bench/periodic_task_dispatcher_tb.sv -----
module periodic_task_dispatcher_tb;
    import ptd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam logic                 POLICY_RM   = 1'b0;
    localparam logic                 POLICY_EDF  = 1'b1;
    localparam logic [NOW_W-1:0]     BASE_MS     = 31'h7FF8_0000;
    localparam logic [NOW_W-1:0]     NOW_TOP     = {NOW_W{1'b1}};
    localparam logic [NOW_W-1:0]     JUMP_ROOM   = 31'd262144;
    localparam int                   STALL_LIMIT = 1000;
    localparam int                   MAX_REPORTS = 10;

    typedef struct packed {
        logic             run_valid;
        logic [RUN_W-1:0] run_task;
        logic             wake_valid;
        logic [NOW_W-1:0] sleep_ms;
    } t_dispatch;

    logic i_clk;
    logic i_rst_n;

    ptd_in_if  in_if();
    ptd_out_if out_if();
    ptd_cfg_if cfg_if();

    periodic_task_dispatcher dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    logic                 edf_mode;
    logic [COUNT_W-1:0]   count_cfg;
    logic [PER_W-1:0]     period_ms [NUM_REGS];
    logic                 sched_started;
    logic [RUN_W-1:0]     cur_task;
    logic [DL_W-1:0]      due_ms [NUM_REGS];
    logic                 task_done [NUM_REGS];

    t_dispatch            pending_dispatch [$];
    t_dispatch            last_dispatch;
    logic [NOW_W-1:0]     clock_ms;
    bit                   calm;
    int                   mismatches;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned draw_idle();
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic logic [PER_W-1:0] draw_period();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            2: return PER_W'(1);
            3, 4, 5, 6: return PER_W'($urandom_range(2, 20));
            default: return PER_W'($urandom_range(21, 400));
        endcase
    endfunction

    function automatic t_dispatch dispatch_next(input logic [NOW_W-1:0] now, input logic fin);
        logic [DL_W-1:0] now_w;
        logic [DL_W-1:0] wake_at;
        logic [DL_W-1:0] gap;
        logic [DL_W:0]   reach;
        int              n;
        int              i;
        int              pick;
        bit              picked;
        bit              waking;
        bit              qual;
        t_dispatch       res;
        now_w   = DL_W'(now);
        n       = (int'(count_cfg) > NUM_TASKS) ? NUM_TASKS : int'(count_cfg);
        picked  = 1'b0;
        waking  = 1'b0;
        pick    = 0;
        wake_at = '0;
        if (!sched_started) begin
            sched_started = 1'b1;
            for (i = 0; i < n; i++) begin
                due_ms[i]    = now_w + DL_W'(period_ms[i]);
                task_done[i] = 1'b0;
            end
        end else if (fin) begin
            task_done[cur_task] = 1'b1;
        end
        // re-arm every task whose deadline has passed, one period at a time
        for (i = 0; i < n; i++) begin
            if (due_ms[i] <= now_w) begin
                due_ms[i]    = due_ms[i] + DL_W'(period_ms[i]);
                task_done[i] = 1'b0;
            end
        end
        for (i = 0; i < n; i++) begin
            if (!task_done[i]) begin
                if (!picked) begin
                    picked = 1'b1;
                    pick   = i;
                end else if (edf_mode == POLICY_RM) begin
                    if (period_ms[i] <= period_ms[pick]) pick = i;
                end else if (due_ms[i] <= due_ms[pick]) begin
                    pick = i;
                end
            end
        end
        for (i = 0; i < n; i++) begin
            reach = {1'b0, due_ms[i]} + {{(DL_W + 1 - PER_W){1'b0}}, period_ms[i]};
            if (!picked) qual = 1'b1;
            else if (edf_mode == POLICY_RM) qual = period_ms[i] < period_ms[pick];
            else qual = reach < {1'b0, due_ms[pick]};
            if (qual && (!waking || due_ms[i] < wake_at)) begin
                waking  = 1'b1;
                wake_at = due_ms[i];
            end
        end
        if (picked) cur_task = RUN_W'(pick);
        res.run_valid  = picked;
        res.run_task   = picked ? RUN_W'(pick) : '0;
        res.wake_valid = waking;
        res.sleep_ms   = '0;
        if (waking && wake_at > now_w) begin
            gap          = wake_at - now_w;
            res.sleep_ms = (gap > DL_W'(SLEEP_MAX)) ? SLEEP_MAX : gap[NOW_W-1:0];
        end
        return res;
    endfunction

    task automatic send_item(input logic [NOW_W-1:0] now, input logic fin);
        int unsigned gap;
        gap = draw_idle();
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.now_ms        <= now;
        in_if.task_finished <= fin;
        do @(posedge i_clk); while (!in_if.ready);
        last_dispatch = dispatch_next(now, fin);
        pending_dispatch.push_back(last_dispatch);
    endtask

    task automatic tick(input int unsigned delta, input logic fin);
        clock_ms = clock_ms + NOW_W'(delta);
        send_item(clock_ms, fin);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        int unsigned gap;
        gap = draw_idle();
        if (gap != 0) begin
            cfg_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            REG_POLICY:  edf_mode     = value[0];
            REG_COUNT:   count_cfg    = value[COUNT_W-1:0];
            REG_PERIOD0: period_ms[0] = value[PER_W-1:0];
            REG_PERIOD1: period_ms[1] = value[PER_W-1:0];
            REG_PERIOD2: period_ms[2] = value[PER_W-1:0];
            REG_PERIOD3: period_ms[3] = value[PER_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic policy, input logic [COUNT_W-1:0] cnt,
                             input logic [PER_W-1:0] p0, input logic [PER_W-1:0] p1,
                             input logic [PER_W-1:0] p2, input logic [PER_W-1:0] p3);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_POLICY, {junk[CFG_DATA_W-1:1], policy});
        write_reg(REG_COUNT, {junk[CFG_DATA_W-1:COUNT_W], cnt});
        write_reg(REG_PERIOD0, CFG_DATA_W'(p0));
        write_reg(REG_PERIOD1, CFG_DATA_W'(p1));
        write_reg(REG_PERIOD2, CFG_DATA_W'(p2));
        write_reg(REG_PERIOD3, CFG_DATA_W'(p3));
        // unmapped index, must not disturb anything
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
        cfg_if.valid <= 1'b0;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending_dispatch.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        clock_ms = BASE_MS;
        send_item(clock_ms, 1'b0);
        tick(0, 1'b1);
        tick(10, 1'b1);
        tick(10, 1'b1);
        tick(10, 1'b1);
        tick(70, 1'b0);
        tick(30, 1'b1);
        drain();
    endtask

    task automatic test_rate_monotonic();
        configure(POLICY_RM, 3'd4, 16'd40, 16'd40, 16'd10, 16'hFFFF);
        tick(25, 1'b0);
        tick(5, 1'b1);
        tick(40, 1'b1);
        tick(40, 1'b0);
        tick(10, 1'b1);
        drain();
    endtask

    task automatic test_task_count();
        logic [COUNT_W-1:0] counts [6];
        int                 k;
        counts = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd7};
        for (k = 0; k < 6; k++) begin
            configure(POLICY_EDF, counts[k], 16'd30, 16'd20, 16'd10, 16'd50);
            tick(15, 1'($urandom_range(0, 1)));
            drain();
        end
    endtask

    task automatic test_period_extremes();
        configure(POLICY_EDF, 3'd4, 16'd0, 16'd1, 16'hFFFF, 16'd7);
        tick(0, 1'b1);
        tick(1, 1'b0);
        tick(3, 1'b1);
        drain();
        configure(POLICY_RM, 3'd6, 16'd0, 16'hFFFF, 16'd1, 16'd1);
        tick(1, 1'b1);
        tick(2, 1'b1);
        drain();
    endtask

    task automatic test_random_traffic();
        int ph;
        int k;
        for (ph = 0; ph < 8; ph++) begin
            calm = ($urandom_range(0, 3) == 0);
            configure(1'($urandom_range(0, 1)),
                      ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom_range(0, 7)) : 3'd4,
                      draw_period(), draw_period(), draw_period(), draw_period());
            for (k = 0; k < 80; k++) begin
                case ($urandom_range(0, 15))
                    // out-of-order timestamp: never ahead of the running clock
                    0: send_item(NOW_W'($urandom_range(0, clock_ms)), 1'($urandom_range(0, 1)));
                    1: begin
                        if (clock_ms < BASE_MS + JUMP_ROOM)
                            tick($urandom_range(1000, 30000), 1'b0);
                        else
                            tick($urandom_range(0, 60), 1'($urandom_range(0, 1)));
                    end
                    2, 3, 4, 5, 6, 7: begin
                        // wake exactly when the dispatcher asked to
                        if (last_dispatch.wake_valid && last_dispatch.sleep_ms <= 5000)
                            tick(last_dispatch.sleep_ms, 1'($urandom_range(0, 3) == 0));
                        else
                            tick($urandom_range(0, 60), 1'($urandom_range(0, 1)));
                    end
                    default: tick($urandom_range(0, 60), 1'($urandom_range(0, 1)));
                endcase
            end
            drain();
            calm = 1'b0;
        end
    endtask

    task automatic test_sleep_saturation();
        bit behind;
        int i;
        int k;
        configure(POLICY_EDF, 3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // push every deadline past the top of the time range
        do begin
            send_item(NOW_TOP, 1'b0);
            behind = 1'b0;
            for (i = 0; i < NUM_REGS; i++)
                if (due_ms[i] <= DL_W'(NOW_TOP)) behind = 1'b1;
        end while (behind);
        for (k = 0; k < 5; k++) send_item('0, 1'b1);
        send_item(NOW_TOP, 1'b1);
        drain();
    endtask

    initial begin
        t_dispatch got;
        t_dispatch want;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            int unsigned stall;
            stall = draw_idle();
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            got.run_valid  = out_if.run_valid;
            got.run_task   = out_if.run_task;
            got.wake_valid = out_if.wake_valid;
            got.sleep_ms   = out_if.sleep_ms;
            if (pending_dispatch.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"%0t: result beat with nothing expected: ",
                              "run %0b/%0d wake %0b/%0d"},
                             $time, got.run_valid, got.run_task, got.wake_valid, got.sleep_ms);
            end else begin
                want = pending_dispatch.pop_front();
                if (got.run_valid !== want.run_valid || got.run_task !== want.run_task ||
                    got.wake_valid !== want.wake_valid || got.sleep_ms !== want.sleep_ms) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: dispatch mismatch: expected run %0b/%0d wake %0b/%0d, ",
                                  "got run %0b/%0d wake %0b/%0d"},
                                 $time, want.run_valid, want.run_task, want.wake_valid,
                                 want.sleep_ms, got.run_valid, got.run_task, got.wake_valid,
                                 got.sleep_ms);
                end
            end
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int i;
        i_rst_n             <= 1'b0;
        in_if.valid         <= 1'b0;
        in_if.now_ms        <= '0;
        in_if.task_finished <= 1'b0;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= '0;
        cfg_if.data         <= '0;
        edf_mode      = POLICY_RST;
        count_cfg     = COUNT_RST;
        sched_started = 1'b0;
        cur_task      = '0;
        for (i = 0; i < NUM_REGS; i++) begin
            period_ms[i] = PERIOD_RST;
            due_ms[i]    = '0;
            task_done[i] = 1'b0;
        end
        last_dispatch = '0;
        clock_ms      = BASE_MS;
        calm          = 1'b0;
        mismatches    = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_rate_monotonic();
        test_task_count();
        test_period_extremes();
        test_random_traffic();
        test_sleep_saturation();

        repeat (3 * NUM_TASKS + 8) @(posedge i_clk);
        if (mismatches == 0 && pending_dispatch.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
